/* hw/rtl/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// rrts_pkg: shared constants and types
// Slot count, operation codes and task state codes of the round-robin scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;
	localparam int SLOTS = 16;
	localparam int SW = $clog2(SLOTS);
	localparam int LW = SW + 1;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);
	localparam logic [7:0] QUANTUM_RESET = 8'd10;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_TICK = 3'd2;
	localparam logic [2:0] OP_YIELD = 3'd3;
	localparam logic [2:0] OP_BLOCK = 3'd4;
	localparam logic [2:0] OP_UNBLOCK = 3'd5;
	localparam logic [2:0] OP_FIND = 3'd6;

	localparam logic [2:0] ST_NEW = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_RUNNING = 3'd2;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_TERM = 3'd4;

	typedef logic [LW-1:0] link_t;
endpackage

/* hw/rtl/round_robin_task_scheduler_core.sv */
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_core
// Task slot table with a linked ready queue, time quantum and pid lookup.
// ----------------------------------------------------------------------------
// add and unblock append the slot at the tail; tick, yield, block and remove may pop
// a new head; find checks the running slot, then walks the ready queue from the head.
// one transaction at a time: busy is high from start until the result strobe.
// link updates are sequencer steps: unlink predecessor side, successor side, append.
// reset clears all slots, queue and phase at once and sets the pid counter to 1; the result
// strobe cannot be stalled by the receiver.
module round_robin_task_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic [2:0]  operation,
	input  logic [3:0]  slot,
	input  logic [31:0] pid,
	output logic        done,
	output logic        current_valid,
	output logic [3:0]  current_slot,
	output logic        switched,
	output logic        found_valid,
	output logic [3:0]  found_slot,
	output logic [2:0]  slot_state,
	output logic [31:0] slot_pid,
	output logic [31:0] slot_cpu_time
);
	import rrts_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_UNL    = 4'd2;  // unlink u_q: fix predecessor side
	localparam logic [3:0] S_UNL2   = 4'd3;  // unlink u_q: fix successor side
	localparam logic [3:0] S_APP    = 4'd4;  // append u_q at tail
	localparam logic [3:0] S_YLD    = 4'd5;  // yield entry
	localparam logic [3:0] S_POP    = 4'd6;  // take head as running
	localparam logic [3:0] S_FIND   = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	// continuation after an unlink
	localparam logic [1:0] K_NONE  = 2'd0;
	localparam logic [1:0] K_APP   = 2'd1;
	localparam logic [1:0] K_YIELD = 2'd2;
	localparam logic [1:0] K_POP   = 2'd3;

	logic [2:0]  st_q  [SLOTS];
	logic [31:0] pid_q [SLOTS];
	logic [31:0] cpu_q [SLOTS];
	link_t       fwd_q [SLOTS];
	link_t       bwd_q [SLOTS];
	link_t       head_q, tail_q, run_q;
	logic [31:0] pidc_q;
	logic [7:0]  phase_q, quantum_q;

	logic [3:0]  state_q;
	logic [2:0]  op_q;
	logic [3:0]  slot_q;
	logic [31:0] want_q;
	link_t       u_q, w_q, prev_q;
	logic [1:0]  k_q;
	logic [LW-1:0] cnt_q;
	logic        sw_q, fnd_q;
	logic [3:0]  fat_q;
	logic        unl_pn_q;

	logic [SW-1:0] ui, ti, ri, wi;
	logic [7:0]  ph_inc;
	logic        wrap;
	assign ui = u_q[SW-1:0];
	assign ti = tail_q[SW-1:0];
	assign ri = run_q[SW-1:0];
	assign wi = w_q[SW-1:0];
	assign ph_inc = phase_q + 8'd1;
	assign wrap = ph_inc >= quantum_q;

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				st_q[i] <= ST_NEW;
				pid_q[i] <= '0;
				cpu_q[i] <= '0;
				fwd_q[i] <= NIL;
				bwd_q[i] <= NIL;
			end
			head_q <= NIL;
			tail_q <= NIL;
			run_q <= NIL;
			pidc_q <= 32'd1;
			phase_q <= '0;
			quantum_q <= QUANTUM_RESET;
			state_q <= S_IDLE;
			op_q <= '0;
			slot_q <= '0;
			want_q <= '0;
			u_q <= NIL;
			w_q <= NIL;
			prev_q <= NIL;
			k_q <= K_NONE;
			cnt_q <= '0;
			sw_q <= 1'b0;
			fnd_q <= 1'b0;
			fat_q <= '0;
			unl_pn_q <= 1'b0;
			done <= 1'b0;
			current_valid <= 1'b0;
			current_slot <= '0;
			switched <= 1'b0;
			found_valid <= 1'b0;
			found_slot <= '0;
			slot_state <= '0;
			slot_pid <= '0;
			slot_cpu_time <= '0;
		end else begin
			done <= state_q == S_DONE;
			if (cfg_we)
				quantum_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= operation;
						slot_q <= slot;
						want_q <= pid;
						sw_q <= 1'b0;
						fnd_q <= 1'b0;
						fat_q <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_DONE;
					case (op_q)
						OP_ADD: begin
							if (pid_q[slot_q] == 32'd0) begin
								pid_q[slot_q] <= pidc_q;
								pidc_q <= pidc_q + 32'd1;
							end
							if (st_q[slot_q] != ST_READY) begin
								st_q[slot_q] <= ST_READY;
								u_q <= LW'(slot_q);
								k_q <= K_APP;
								state_q <= S_UNL;
							end
						end
						OP_REMOVE: begin
							if (LW'(slot_q) == run_q) begin
								run_q <= NIL;
								st_q[slot_q] <= ST_TERM;
							end
							if (st_q[slot_q] == ST_READY) begin
								u_q <= LW'(slot_q);
								k_q <= (LW'(slot_q) == run_q) ? K_YIELD : K_NONE;
								state_q <= S_UNL;
							end else if (LW'(slot_q) == run_q) begin
								state_q <= S_YLD;
							end
						end
						OP_TICK: begin
							phase_q <= wrap ? 8'd0 : ph_inc;
							if (run_q == NIL)
								state_q <= S_YLD;
							else begin
								cpu_q[ri] <= cpu_q[ri] + 32'd1;
								if (wrap)
									state_q <= S_YLD;
							end
						end
						OP_YIELD: state_q <= S_YLD;
						OP_BLOCK: begin
							if (run_q != NIL) begin
								st_q[ri] <= ST_BLOCKED;
								state_q <= S_YLD;
							end
						end
						OP_UNBLOCK: begin
							if (st_q[slot_q] == ST_BLOCKED) begin
								st_q[slot_q] <= ST_READY;
								u_q <= LW'(slot_q);
								k_q <= K_APP;
								state_q <= S_UNL;
							end
						end
						OP_FIND: begin
							if (run_q != NIL && pid_q[ri] == want_q) begin
								fnd_q <= 1'b1;
								fat_q <= 4'(ri);
							end else begin
								w_q <= head_q;
								cnt_q <= '0;
								state_q <= S_FIND;
							end
						end
						default: ;
					endcase
				end
				S_UNL: begin
					// predecessor side; a slot not in the queue is marked so its links stay untouched
					unl_pn_q <= 1'b0;
					if (bwd_q[ui] != NIL) begin
						fwd_q[bwd_q[ui][SW-1:0]] <= fwd_q[ui];
						state_q <= S_UNL2;
					end else if (head_q == u_q) begin
						head_q <= fwd_q[ui];
						state_q <= S_UNL2;
					end else begin
						unl_pn_q <= 1'b1;
						state_q <= S_UNL2;
					end
				end
				S_UNL2: begin
					if (!unl_pn_q) begin
						if (fwd_q[ui] != NIL)
							bwd_q[fwd_q[ui][SW-1:0]] <= bwd_q[ui];
						else if (tail_q == u_q)
							tail_q <= bwd_q[ui];
						fwd_q[ui] <= NIL;
						bwd_q[ui] <= NIL;
					end
					case (k_q)
						K_APP: state_q <= S_APP;
						K_YIELD: state_q <= S_YLD;
						K_POP: state_q <= S_POP;
						default: state_q <= S_DONE;
					endcase
				end
				S_APP: begin
					fwd_q[ui] <= NIL;
					if (head_q == NIL) begin
						bwd_q[ui] <= NIL;
						head_q <= u_q;
						tail_q <= u_q;
					end else begin
						fwd_q[ti] <= u_q;
						bwd_q[ui] <= tail_q;
						tail_q <= u_q;
					end
					// after requeue in a yield, go on to pop the head
					state_q <= (k_q == K_YIELD) ? S_YLD : S_DONE;
					if (k_q == K_YIELD)
						k_q <= K_POP;
				end
				S_YLD: begin
					if (head_q == NIL)
						state_q <= S_DONE;
					else if (k_q != K_POP && run_q != NIL && st_q[ri] == ST_RUNNING) begin
						// a running slot is never linked, so it goes straight to the tail
						st_q[ri] <= ST_READY;
						u_q <= run_q;
						k_q <= K_YIELD;
						state_q <= S_APP;
					end else begin
						u_q <= head_q;
						k_q <= K_POP;
						state_q <= S_UNL;
						prev_q <= run_q;
					end
				end
				S_POP: begin
					run_q <= u_q;
					st_q[ui] <= ST_RUNNING;
					if (prev_q != u_q)
						sw_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_FIND: begin
					if (w_q == NIL || cnt_q == LW'(SLOTS))
						state_q <= S_DONE;
					else if (pid_q[wi] == want_q) begin
						fnd_q <= 1'b1;
						fat_q <= 4'(wi);
						state_q <= S_DONE;
					end else begin
						w_q <= fwd_q[wi];
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					current_valid <= run_q != NIL;
					current_slot <= (run_q != NIL) ? 4'(ri) : 4'd0;
					switched <= sw_q;
					found_valid <= fnd_q;
					found_slot <= fnd_q ? fat_q : 4'd0;
					slot_state <= st_q[slot_q];
					slot_pid <= pid_q[slot_q];
					slot_cpu_time <= cpu_q[slot_q];
					k_q <= K_NONE;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
